// ===== sv/multichannel_moving_average_percent_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the moving average percent unit
// Shared checking shorthands; each expands to one labeled concurrent check.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_PERCENT_UNIT_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_PERCENT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define MMAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define MMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mmap_pkg.sv =====
// ---------------------------------------------------------------------------
// Moving average percent unit package
// Fixed field widths, constants, the sequencer state type and divider status.
// ---------------------------------------------------------------------------
package mmap_pkg;

  // Fixed widths of the interface fields.
  localparam int ID_W     = 8;
  localparam int SAMPLE_W = 16;
  localparam int FS_W     = 16;
  localparam int PCT_W    = 16;

  // Full-scale register reset value (about 1.05 in Q4.12).
  localparam logic [FS_W-1:0] FS_RESET = 16'd4301;

  // Percent scaling and the bits it adds to the numerator.
  localparam int PERCENT_SCALE = 100;
  localparam int SCALE_W       = 7;

  // Saturation limits of the result and the bad-channel error code.
  localparam logic [PCT_W-1:0] PCT_MAX   = 16'h7FFF;
  localparam logic [PCT_W-1:0] PCT_MIN   = 16'h8000;
  localparam logic [PCT_W-1:0] PCT_ERROR = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_OLD,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/mmap_divider.sv =====
// ---------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mmap_divider
  import mmap_pkg::*;
#(
  parameter int NUM_W = 27,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    trial = {rem, q[NUM_W-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  // Control: count the quotient bits and flag completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

// ===== sv/multichannel_moving_average_percent_unit.sv =====
// ---------------------------------------------------------------------------
// Multichannel moving average percent unit
// Keeps a ring of recent torque samples per channel and reports the window
// mean as a saturated percentage of the configured full-scale torque.
// ---------------------------------------------------------------------------
//
//   Channel  Signals                                   Direction
//   -------  ----------------------------------------  ---------
//   in       in_valid, in_ready, channel_id,           sink
//            torque_sample
//   out      out_valid, out_ready, percent,            source
//            bad_channel
//   cfg      cfg_wr_en, cfg_wr_data                    sink
//
// A primed-channel sample goes through lookup, ring replacement, divider start
// and the bit-serial divider before its result is registered; the next input
// transfer is taken only once that result has been loaded. A first sample also
// fills the ring; an out-of-range channel number goes straight to the result.
// Reset clears the primed flags, the sequencer and the output valid flag.
// A stalled result holds only the finish of the next item, not its transfer.
//
`include "multichannel_moving_average_percent_unit_defines.svh"

module multichannel_moving_average_percent_unit
  import mmap_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ID_W-1:0]            channel_id,
  input  logic signed [SAMPLE_W-1:0] torque_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [PCT_W-1:0]    percent,
  output logic                       bad_channel,
  input  logic                       cfg_wr_en,
  input  logic [FS_W-1:0]            cfg_wr_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int ADDR_W = CH_W + SLOT_W;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int NUM_W  = SUM_W + SCALE_W;
  localparam int DEN_W  = FS_W + $clog2(WINDOW + 1);

  localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic signed [SUM_W-1:0] WIN_S     = SUM_W'(WINDOW);

  state_t state;
  state_t state_next;

  // Configuration register.
  logic [FS_W-1:0] full_scale;
  logic [FS_W-1:0] fs_eff;

  // Item registers.
  logic [CH_W-1:0]            ch;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       bad;
  logic signed [SUM_W-1:0]    sum_reg;
  logic                       neg;
  logic [SLOT_W-1:0]          fill_cnt;
  logic [CHANNELS-1:0]        primed;

  // Input decode.
  logic [ID_W-1:0] id_m1;
  logic [CH_W-1:0] in_ch;
  logic            in_bad;

  // Memories and their registered read data.
  logic [SAMPLE_W-1:0] sample_mem [2**ADDR_W];
  logic [SLOT_W-1:0]   slot_mem   [CHANNELS];
  logic [SUM_W-1:0]    sum_mem    [CHANNELS];
  logic [SAMPLE_W-1:0] sample_rd;
  logic [SLOT_W-1:0]   slot_rd;
  logic signed [SUM_W-1:0] sum_rd;

  // Sequencer outputs.
  logic in_xfer;
  logic sample_we;
  logic chan_we;
  logic div_start;
  logic out_load;
  logic fill_last;

  // Datapath values.
  logic [ADDR_W-1:0]       sample_addr;
  logic [SLOT_W-1:0]       slot_new;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic [SUM_W-1:0]        sum_mag;
  logic [NUM_W-1:0]        dividend;
  logic [DEN_W-1:0]        divisor;
  logic [NUM_W-1:0]        quotient;
  logic [PCT_W-1:0]        pct_sat;
  logic [PCT_W-1:0]        pct_next;
  div_stat_t               div_stat;

  // Input channel decode: one-based number to ring index.
  always_comb begin
    id_m1  = channel_id - ID_W'(1);
    in_ch  = id_m1[CH_W-1:0];
    in_bad = (channel_id == '0) || (channel_id > ID_W'(CHANNELS));
  end

  // Full-scale register; a zero setting behaves as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg_wr_en) begin
      full_scale <= cfg_wr_data;
    end
  end

  assign fs_eff = (full_scale == '0) ? FS_W'(1) : full_scale;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_bad ? ST_DONE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = primed[ch] ? ST_OLD : ST_FILL;
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_CALC;
        end
      end
      ST_OLD:  state_next = ST_CALC;
      ST_CALC: state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    sample_we = 1'b0;
    chan_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_FILL: begin
        sample_we = 1'b1;
        chan_we   = fill_last;
      end
      ST_OLD: begin
        sample_we = 1'b1;
        chan_we   = 1'b1;
      end
      ST_CALC: div_start = 1'b1;
      ST_DONE: out_load  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  assign in_xfer   = in_valid && in_ready;
  assign fill_last = (fill_cnt == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item at its input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch     <= in_ch;
      sample <= torque_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad <= 1'b0;
    end else if (in_xfer) begin
      bad <= in_bad;
    end
  end

  // Ring fill counter used while priming a channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (state == ST_LOOKUP) begin
      fill_cnt <= '0;
    end else if (state == ST_FILL) begin
      fill_cnt <= fill_cnt + SLOT_W'(1);
    end
  end

  // Primed flags, one per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (state == ST_FILL && fill_last) begin
      primed[ch] <= 1'b1;
    end
  end

  // Running sum update: a fresh fill or replacement of the oldest sample.
  always_comb begin
    sample_ext = {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    old_ext    = {{(SUM_W - SAMPLE_W){sample_rd[SAMPLE_W-1]}}, sample_rd};
    if (state == ST_FILL) begin
      sum_new     = sample_ext * WIN_S;
      slot_new    = SLOT_W'(1);
      sample_addr = {ch, fill_cnt};
    end else begin
      sum_new     = sum_rd - old_ext + sample_ext;
      slot_new    = (slot_rd == SLOT_LAST) ? '0 : slot_rd + SLOT_W'(1);
      sample_addr = {ch, slot_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (chan_we) begin
      sum_reg <= sum_new;
    end
  end

  // Channel state memory: ring slot and running sum, read at the transfer.
  always_ff @(posedge clk) begin
    if (chan_we) begin
      slot_mem[ch] <= slot_new;
      sum_mem[ch]  <= sum_new;
    end
    if (state == ST_IDLE) begin
      slot_rd <= slot_mem[in_ch];
      sum_rd  <= sum_mem[in_ch];
    end
  end

  // Sample ring memory, one row of slots per channel.
  always_ff @(posedge clk) begin
    if (sample_we) begin
      sample_mem[sample_addr] <= sample;
    end
    if (state == ST_LOOKUP) begin
      sample_rd <= sample_mem[sample_addr];
    end
  end

  // Divider operands: magnitude of sum times 100 over window times full scale.
  always_comb begin
    sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
    dividend = NUM_W'(sum_mag) * NUM_W'(PERCENT_SCALE);
    divisor  = DEN_W'(fs_eff) * DEN_W'(WINDOW);
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg <= sum_reg[SUM_W-1];
    end
  end

  mmap_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Restore the sign and saturate to 16 bits.
  always_comb begin
    if (neg) begin
      if (quotient > NUM_W'(32768)) begin
        pct_sat = PCT_MIN;
      end else begin
        pct_sat = ~quotient[PCT_W-1:0] + PCT_W'(1);
      end
    end else begin
      if (quotient > NUM_W'(32767)) begin
        pct_sat = PCT_MAX;
      end else begin
        pct_sat = quotient[PCT_W-1:0];
      end
    end
    pct_next = bad ? PCT_ERROR : pct_sat;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      percent     <= pct_next;
      bad_channel <= bad;
    end
  end

  // Checks on the sequencer and datapath.
  `MMAP_ASSERT_NOW(a_bad_is_error_code, out_valid && bad_channel, percent == PCT_ERROR, "bad channel result must read minus one")
  `MMAP_ASSERT_NOW(a_div_only_in_div, div_stat.busy, state == ST_DIV, "divider busy outside the divide state")
  `MMAP_ASSERT_NOW(a_replace_needs_primed, state == ST_OLD, primed[ch], "ring replacement on an unprimed channel")
  `MMAP_ASSERT_NEXT(a_one_item_at_a_time, in_xfer, !in_ready, "input accepted again before the item finished")

endmodule
